>>> hdl/ctt_pkg.sv
// shared types, codes and character classes for the config text tokenizer
`timescale 1ns / 1ps
`default_nettype none

package ctt_pkg;

   localparam int LINE_BITS_DEF   = 20;
   localparam int COL_BITS_DEF    = 16;
   localparam int OFFSET_BITS_DEF = 24;
   localparam int KIND_BITS       = 5;

   // scan modes
   typedef enum logic [3:0] {
      MODE_IDLE    = 4'd0,
      MODE_IDENT   = 4'd1,
      MODE_NUMBER  = 4'd2,
      MODE_STRING  = 4'd3,
      MODE_SLASH   = 4'd4,
      MODE_PLUS    = 4'd5,
      MODE_DOT     = 4'd6,
      MODE_LINECOM = 4'd7,
      MODE_BLOCK   = 4'd8,
      MODE_BSTAR   = 4'd9
   } mode_type;

   // token kinds
   localparam logic [KIND_BITS-1:0] KIND_IDENT   = 5'd0;
   localparam logic [KIND_BITS-1:0] KIND_BOOL    = 5'd1;
   localparam logic [KIND_BITS-1:0] KIND_NUMBER  = 5'd2;
   localparam logic [KIND_BITS-1:0] KIND_STRING  = 5'd3;
   localparam logic [KIND_BITS-1:0] KIND_EQUALS  = 5'd4;
   localparam logic [KIND_BITS-1:0] KIND_PLUSEQ  = 5'd5;
   localparam logic [KIND_BITS-1:0] KIND_LBRACK  = 5'd6;
   localparam logic [KIND_BITS-1:0] KIND_RBRACK  = 5'd7;
   localparam logic [KIND_BITS-1:0] KIND_LPAREN  = 5'd8;
   localparam logic [KIND_BITS-1:0] KIND_RPAREN  = 5'd9;
   localparam logic [KIND_BITS-1:0] KIND_PLUS    = 5'd10;
   localparam logic [KIND_BITS-1:0] KIND_MINUS   = 5'd11;
   localparam logic [KIND_BITS-1:0] KIND_STAR    = 5'd12;
   localparam logic [KIND_BITS-1:0] KIND_SLASH   = 5'd13;
   localparam logic [KIND_BITS-1:0] KIND_PERCENT = 5'd14;
   localparam logic [KIND_BITS-1:0] KIND_LBRACE  = 5'd15;
   localparam logic [KIND_BITS-1:0] KIND_RBRACE  = 5'd16;
   localparam logic [KIND_BITS-1:0] KIND_COMMA   = 5'd17;
   localparam logic [KIND_BITS-1:0] KIND_COLON   = 5'd18;
   localparam logic [KIND_BITS-1:0] KIND_AT      = 5'd19;
   localparam logic [KIND_BITS-1:0] KIND_DOLLAR  = 5'd20;
   localparam logic [KIND_BITS-1:0] KIND_DOT     = 5'd22;
   localparam logic [KIND_BITS-1:0] KIND_BANG    = 5'd23;
   localparam logic [KIND_BITS-1:0] KIND_QUEST   = 5'd24;
   localparam logic [KIND_BITS-1:0] KIND_UNEXP   = 5'd25;
   localparam logic [KIND_BITS-1:0] KIND_OPENSTR = 5'd26;
   localparam logic [KIND_BITS-1:0] KIND_OPENCOM = 5'd27;
   localparam logic [KIND_BITS-1:0] KIND_EOF     = 5'd28;

   // keyword progress codes
   localparam logic [3:0] KW_NONE   = 4'd0;
   localparam logic [3:0] KW_T      = 4'd1;
   localparam logic [3:0] KW_TRUE   = 4'd4;
   localparam logic [3:0] KW_F      = 4'd5;
   localparam logic [3:0] KW_FALSE  = 4'd9;

   localparam logic [7:0] CH_NL    = 8'h0A;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   typedef struct packed {
      logic [7:0] ch;
      logic       is_end;
   } req_type;

   // token event from the scanner to the output side
   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic [1:0]           sel;
      logic                 last;
   } evt_type;

   localparam logic [1:0] SEL_TOKEN = 2'd0;
   localparam logic [1:0] SEL_HERE  = 2'd1;
   localparam logic [1:0] SEL_EOF   = 2'd2;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == " " || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic logic is_identch(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == CH_UNDER || c == CH_HASH;
   endfunction

   function automatic logic [3:0] kw_next_prog(input logic [3:0] p, input logic [7:0] c);
      logic [7:0] want;
      case (p)
         4'd1:    want = "r";
         4'd2:    want = "u";
         4'd3:    want = "e";
         4'd5:    want = "a";
         4'd6:    want = "l";
         4'd7:    want = "s";
         4'd8:    want = "e";
         default: want = 8'd0;
      endcase
      return (want != 8'd0 && c == want) ? p + 4'd1 : KW_NONE;
   endfunction

   function automatic logic [KIND_BITS-1:0] punct_kind(input logic [7:0] c);
      case (c)
         "[":     return KIND_LBRACK;
         "]":     return KIND_RBRACK;
         "(":     return KIND_LPAREN;
         ")":     return KIND_RPAREN;
         "-":     return KIND_MINUS;
         "*":     return KIND_STAR;
         "%":     return KIND_PERCENT;
         "{":     return KIND_LBRACE;
         "}":     return KIND_RBRACE;
         ",":     return KIND_COMMA;
         ":":     return KIND_COLON;
         "@":     return KIND_AT;
         "$":     return KIND_DOLLAR;
         "!":     return KIND_BANG;
         "?":     return KIND_QUEST;
         default: return KIND_UNEXP;
      endcase
   endfunction

endpackage

`default_nettype wire

>>> hdl/ctt_scan.sv
// front end: scan state, position counters and token events
`timescale 1ns / 1ps
`default_nettype none

module ctt_scan import ctt_pkg::*; #(
   parameter int LINE_BITS   = LINE_BITS_DEF,
   parameter int COL_BITS    = COL_BITS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          in_valid,
   input  wire req_type       in_item,
   output logic               in_ready,
   output logic               push,
   output logic [1:0]         push_count,
   output evt_type            evt0,
   output evt_type            evt1,
   output logic [LINE_BITS-1:0]   tok_line,
   output logic [COL_BITS-1:0]    tok_col,
   output logic [OFFSET_BITS-1:0] tok_off,
   output logic [OFFSET_BITS-1:0] tok_len,
   output logic [LINE_BITS-1:0]   here_line,
   output logic [COL_BITS-1:0]    here_col,
   output logic [OFFSET_BITS-1:0] here_off,
   input  wire logic          queue_room
);

   localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
   localparam logic [COL_BITS-1:0]    COL_MAX  = '1;
   localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
   localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
   localparam logic [COL_BITS-1:0]    COL_ONE  = COL_BITS'(1);

   mode_type                 mode_ff, mode_in;
   logic [LINE_BITS-1:0]     line_ff, line_in, tline_ff, tline_in;
   logic [COL_BITS-1:0]      col_ff, col_in, tcol_ff, tcol_in;
   logic [OFFSET_BITS-1:0]   off_ff, off_in, toff_ff, toff_in, tlen_ff, tlen_in;
   logic [3:0]               kw_ff, kw_in;
   logic                     ended_ff, ended_in;

   logic [7:0]   c;
   logic         take;
   logic         go_idle;
   logic         adv, adv_lines;
   logic [1:0]   n;
   evt_type      e0, e1;
   logic [OFFSET_BITS-1:0] off_inc;
   logic         first_is_token;

   assign c         = in_item.ch;
   assign in_ready  = queue_room;
   assign take      = in_valid && queue_room;
   assign off_inc   = (off_ff == OFF_MAX) ? OFF_MAX : off_ff + 1'b1;

   // per-byte decision logic
   always_comb begin
      mode_in  = mode_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      toff_in  = toff_ff;
      tlen_in  = tlen_ff;
      kw_in    = kw_ff;
      ended_in = ended_ff;
      go_idle  = 1'b0;
      adv      = 1'b0;
      adv_lines = 1'b1;
      n        = 2'd0;
      e0       = '{kind: KIND_EOF, sel: SEL_TOKEN, last: 1'b0};
      e1       = '{kind: KIND_EOF, sel: SEL_TOKEN, last: 1'b0};
      first_is_token = 1'b1;
      if (!ended_ff) begin
         if (in_item.is_end) begin
            n = 2'd1;
            case (mode_ff)
               MODE_IDENT:   e0.kind = (kw_ff == KW_TRUE || kw_ff == KW_FALSE)
                                       ? KIND_BOOL : KIND_IDENT;
               MODE_NUMBER:  e0.kind = KIND_NUMBER;
               MODE_STRING:  e0.kind = KIND_OPENSTR;
               MODE_SLASH:   e0.kind = KIND_SLASH;
               MODE_PLUS:    e0.kind = KIND_PLUS;
               MODE_DOT:     e0.kind = KIND_DOT;
               MODE_BLOCK,
               MODE_BSTAR:   e0.kind = KIND_OPENCOM;
               default:      n = 2'd0;
            endcase
            if (n == 2'd1) begin
               e1 = '{kind: KIND_EOF, sel: SEL_EOF, last: 1'b1};
               n = 2'd2;
            end else begin
               e0 = '{kind: KIND_EOF, sel: SEL_EOF, last: 1'b1};
               n = 2'd1;
            end
            mode_in  = MODE_IDLE;
            ended_in = 1'b1;
         end else begin
            case (mode_ff)
               MODE_IDENT: begin
                  if (is_identch(c)) begin
                     kw_in   = kw_next_prog(kw_ff, c);
                     tlen_in = (tlen_ff == OFF_MAX) ? OFF_MAX : tlen_ff + 1'b1;
                     adv     = 1'b1;
                  end else begin
                     n = 2'd1;
                     e0.kind = (kw_ff == KW_TRUE || kw_ff == KW_FALSE) ? KIND_BOOL : KIND_IDENT;
                     go_idle = 1'b1;
                  end
               end
               MODE_NUMBER: begin
                  if (is_digit(c) || c == ".") begin
                     tlen_in = (tlen_ff == OFF_MAX) ? OFF_MAX : tlen_ff + 1'b1;
                     adv     = 1'b1;
                  end else begin
                     n = 2'd1;
                     e0.kind = KIND_NUMBER;
                     go_idle = 1'b1;
                  end
               end
               MODE_STRING: begin
                  if (c == CH_QUOTE) begin
                     n = 2'd1;
                     e0.kind = KIND_STRING;
                     mode_in = MODE_IDLE;
                  end else begin
                     tlen_in = (tlen_ff == OFF_MAX) ? OFF_MAX : tlen_ff + 1'b1;
                  end
                  adv = 1'b1;
                  adv_lines = 1'b0;
               end
               MODE_SLASH: begin
                  if (c == "/") begin
                     mode_in = MODE_LINECOM;
                     adv = 1'b1;
                  end else if (c == "*") begin
                     mode_in = MODE_BLOCK;
                     tlen_in = (tlen_ff == OFF_MAX) ? OFF_MAX : tlen_ff + 1'b1;
                     adv = 1'b1;
                  end else begin
                     n = 2'd1;
                     e0.kind = KIND_SLASH;
                     go_idle = 1'b1;
                  end
               end
               MODE_PLUS: begin
                  if (c == "=") begin
                     n = 2'd1;
                     e0.kind = KIND_PLUSEQ;
                     first_is_token = 1'b0;
                     mode_in = MODE_IDLE;
                     adv = 1'b1;
                  end else begin
                     n = 2'd1;
                     e0.kind = KIND_PLUS;
                     go_idle = 1'b1;
                  end
               end
               MODE_DOT: begin
                  if (is_digit(c)) begin
                     mode_in = MODE_NUMBER;
                     tlen_in = (tlen_ff == OFF_MAX) ? OFF_MAX : tlen_ff + 1'b1;
                     adv = 1'b1;
                  end else begin
                     n = 2'd1;
                     e0.kind = KIND_DOT;
                     go_idle = 1'b1;
                  end
               end
               MODE_LINECOM: begin
                  if (c == CH_NL) begin
                     go_idle = 1'b1;
                  end else begin
                     adv = 1'b1;
                     adv_lines = 1'b0;
                  end
               end
               MODE_BLOCK, MODE_BSTAR: begin
                  tlen_in = (tlen_ff == OFF_MAX) ? OFF_MAX : tlen_ff + 1'b1;
                  if (mode_ff == MODE_BSTAR && c == "/") begin
                     mode_in = MODE_IDLE;
                  end else begin
                     mode_in = (c == "*") ? MODE_BSTAR : MODE_BLOCK;
                  end
                  adv = 1'b1;
               end
               default: go_idle = 1'b1;
            endcase
            // scan the byte from idle: in idle mode, or after a token or line comment closes
            if (go_idle) begin
               mode_in = MODE_IDLE;
               adv = 1'b1;
               adv_lines = 1'b1;
               if (!is_space(c)) begin
                  tline_in = line_ff;
                  tcol_in  = col_ff;
                  toff_in  = off_ff;
                  tlen_in  = OFFSET_BITS'(1);
                  if (c == "/") begin
                     mode_in = MODE_SLASH;
                  end else if (c == "+") begin
                     mode_in = MODE_PLUS;
                  end else if (is_alpha(c) || c == CH_UNDER || c == CH_HASH) begin
                     mode_in = MODE_IDENT;
                     kw_in = (c == "t") ? KW_T : (c == "f") ? KW_F : KW_NONE;
                  end else if (c == CH_QUOTE) begin
                     mode_in = MODE_STRING;
                     toff_in = off_inc;
                     tlen_in = '0;
                  end else if (is_digit(c)) begin
                     mode_in = MODE_NUMBER;
                  end else if (c == "=") begin
                     if (n == 2'd0) e0 = '{kind: KIND_EQUALS, sel: SEL_HERE, last: 1'b0};
                     else           e1 = '{kind: KIND_EQUALS, sel: SEL_HERE, last: 1'b0};
                     n = n + 2'd1;
                  end else if (c == ".") begin
                     mode_in = MODE_DOT;
                  end else begin
                     if (n == 2'd0) e0 = '{kind: punct_kind(c), sel: SEL_HERE, last: 1'b0};
                     else           e1 = '{kind: punct_kind(c), sel: SEL_HERE, last: 1'b0};
                     n = n + 2'd1;
                  end
               end
            end
            if (!first_is_token) begin
               // plus-equals reports the token start with length two
               e0.sel = SEL_HERE;
            end
            if (n == 2'd1) e0.last = 1'b1;
            if (n == 2'd2) e1.last = 1'b1;
         end
      end
   end

   // position counters
   always_comb begin
      line_in = line_ff;
      col_in  = col_ff;
      off_in  = off_ff;
      if (adv && !in_item.is_end && !ended_ff) begin
         off_in = off_inc;
         if (adv_lines && c == CH_NL) begin
            line_in = (line_ff == LINE_MAX) ? LINE_MAX : line_ff + 1'b1;
            col_in  = COL_ONE;
         end else begin
            col_in = (col_ff == COL_MAX) ? COL_MAX : col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         line_ff  <= LINE_ONE;
         col_ff   <= COL_ONE;
         off_ff   <= '0;
         tline_ff <= LINE_ONE;
         tcol_ff  <= COL_ONE;
         toff_ff  <= '0;
         tlen_ff  <= '0;
         kw_ff    <= KW_NONE;
         ended_ff <= 1'b0;
      end else if (take) begin
         mode_ff  <= mode_in;
         line_ff  <= line_in;
         col_ff   <= col_in;
         off_ff   <= off_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
         toff_ff  <= toff_in;
         tlen_ff  <= tlen_in;
         kw_ff    <= kw_in;
         ended_ff <= ended_in;
      end
   end

   // event outputs; position snapshots taken before this byte
   assign push       = take && (n != 2'd0);
   assign push_count = n;
   assign evt0       = e0;
   assign evt1       = e1;
   assign tok_line   = tline_ff;
   assign tok_col    = tcol_ff;
   assign tok_off    = toff_ff;
   assign tok_len    = tlen_ff;
   assign here_line  = first_is_token ? line_ff : tline_ff;
   assign here_col   = first_is_token ? col_ff : tcol_ff;
   assign here_off   = first_is_token ? off_ff : toff_ff;

endmodule

`default_nettype wire

>>> hdl/ctt_emit.sv
// back end: result queue, resolves events into result items
`timescale 1ns / 1ps
`default_nettype none

module ctt_emit import ctt_pkg::*; #(
   parameter int LINE_BITS   = LINE_BITS_DEF,
   parameter int COL_BITS    = COL_BITS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF,
   localparam int RW = KIND_BITS + LINE_BITS + COL_BITS + 2 * OFFSET_BITS + 1
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire logic [1:0]             push_count,
   input  wire evt_type                evt0,
   input  wire evt_type                evt1,
   input  wire logic [LINE_BITS-1:0]   tok_line,
   input  wire logic [COL_BITS-1:0]    tok_col,
   input  wire logic [OFFSET_BITS-1:0] tok_off,
   input  wire logic [OFFSET_BITS-1:0] tok_len,
   input  wire logic [LINE_BITS-1:0]   here_line,
   input  wire logic [COL_BITS-1:0]    here_col,
   input  wire logic [OFFSET_BITS-1:0] here_off,
   output logic                        queue_room,
   output logic                        out_valid,
   output logic [RW-1:0]               out_item,
   input  wire logic                   out_stall
);

   localparam int DEPTH = 4;

   logic [RW-1:0] q_ff [DEPTH];
   logic [1:0]    wp_ff, wp_in, rp_ff, rp_in;
   logic [2:0]    cnt_ff, cnt_in;
   logic [RW-1:0] r0, r1;
   logic          pop;

   // build a result from an event
   function automatic logic [RW-1:0] build(input evt_type e,
      input logic [LINE_BITS-1:0] tl, input logic [COL_BITS-1:0] tc,
      input logic [OFFSET_BITS-1:0] to, input logic [OFFSET_BITS-1:0] tn,
      input logic [LINE_BITS-1:0] hl, input logic [COL_BITS-1:0] hc,
      input logic [OFFSET_BITS-1:0] ho, input logic [OFFSET_BITS-1:0] hn);
      logic [RW-1:0] r;
      case (e.sel)
         SEL_TOKEN: r = {e.kind, tl, tc, to, tn, e.last};
         SEL_HERE:  r = {e.kind, hl, hc, ho, hn, e.last};
         default:   r = {e.kind, hl, hc, ho, {OFFSET_BITS{1'b0}}, e.last};
      endcase
      return r;
   endfunction

   // eof uses the current counters and length zero; a single-byte token uses length one, plus-equals two
   always_comb begin
      r0 = build(evt0, tok_line, tok_col, tok_off, tok_len,
                 here_line, here_col, here_off,
                 (evt0.kind == KIND_PLUSEQ) ? OFFSET_BITS'(2) : OFFSET_BITS'(1));
      r1 = build(evt1, tok_line, tok_col, tok_off, tok_len,
                 here_line, here_col, here_off, OFFSET_BITS'(1));
   end

   assign queue_room = (cnt_ff <= 3'(DEPTH - 2));
   assign out_valid  = (cnt_ff != 3'd0);
   assign out_item   = q_ff[rp_ff];
   assign pop        = out_valid && !out_stall;

   // queue pointers
   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wp_in  = wp_ff + push_count;
         cnt_in = cnt_in + {1'b0, push_count};
      end
      if (pop) begin
         rp_in  = rp_ff + 2'd1;
         cnt_in = cnt_in - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= r0;
         if (push_count == 2'd2) q_ff[wp_ff + 2'd1] <= r1;
      end
   end

endmodule

`default_nettype wire

>>> hdl/config_text_tokenizer_top.sv
// top level of the config text tokenizer
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid, req_stall | req_item (ch, is_end)
//   rsp     | out | rsp_valid, rsp_stall | rsp_kind .. rsp_last
//
// one byte item per cycle while req_stall is low; the scanner classifies each item combinationally
// up to two results per item go into a four-entry result queue, drained one per cycle while rsp_stall is low
// req_stall rises while the queue has fewer than two free entries
// synchronous reset returns the scanner to line 1, column 1, offset 0
// inputs after the end marker are taken and ignored until reset
`timescale 1ns / 1ps
`default_nettype none

module config_text_tokenizer_top import ctt_pkg::*; #(
   parameter int LINE_BITS   = LINE_BITS_DEF,
   parameter int COL_BITS    = COL_BITS_DEF,
   parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire req_type req_item,
   output logic         req_stall,
   output logic         rsp_valid,
   output logic [KIND_BITS-1:0]   rsp_kind,
   output logic [LINE_BITS-1:0]   rsp_start_line,
   output logic [COL_BITS-1:0]    rsp_start_column,
   output logic [OFFSET_BITS-1:0] rsp_text_offset,
   output logic [OFFSET_BITS-1:0] rsp_text_length,
   output logic                   rsp_last,
   input  wire logic    rsp_stall
);

   localparam int RW = KIND_BITS + LINE_BITS + COL_BITS + 2 * OFFSET_BITS + 1;

   logic ready, push, room;
   logic [1:0] cnt;
   evt_type e0, e1;
   logic [LINE_BITS-1:0] tl, hl;
   logic [COL_BITS-1:0] tc, hc;
   logic [OFFSET_BITS-1:0] to, tn, ho;
   logic [RW-1:0] ritem;

   ctt_scan #(.LINE_BITS(LINE_BITS), .COL_BITS(COL_BITS), .OFFSET_BITS(OFFSET_BITS)) u_scan (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_item(req_item),
      .in_ready(ready), .push(push), .push_count(cnt), .evt0(e0), .evt1(e1),
      .tok_line(tl), .tok_col(tc), .tok_off(to), .tok_len(tn),
      .here_line(hl), .here_col(hc), .here_off(ho),
      .queue_room(room)
   );

   ctt_emit #(.LINE_BITS(LINE_BITS), .COL_BITS(COL_BITS), .OFFSET_BITS(OFFSET_BITS)) u_emit (
      .clock(clock), .reset(reset), .push(push), .push_count(cnt),
      .evt0(e0), .evt1(e1), .tok_line(tl), .tok_col(tc), .tok_off(to), .tok_len(tn),
      .here_line(hl), .here_col(hc), .here_off(ho),
      .queue_room(room), .out_valid(rsp_valid), .out_item(ritem), .out_stall(rsp_stall)
   );

   assign req_stall = !ready;
   assign {rsp_kind, rsp_start_line, rsp_start_column, rsp_text_offset,
           rsp_text_length, rsp_last} = ritem;

endmodule

`default_nettype wire

>>> test/tb_top.sv
// self-checking testbench for the config text tokenizer: token stream prediction and compare
`timescale 1ns / 1ps

module tb_top;
   import ctt_pkg::*;

   // one expected or observed token descriptor
   typedef struct {
      logic [KIND_BITS-1:0] kind;
      logic [19:0]          line;
      logic [15:0]          col;
      logic [23:0]          off;
      logic [23:0]          len;
      logic                 last;
   } token_desc_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   req_type     req_item = '0;
   logic        req_stall;
   logic        rsp_valid;
   logic [4:0]  rsp_kind;
   logic [19:0] rsp_start_line;
   logic [15:0] rsp_start_column;
   logic [23:0] rsp_text_offset;
   logic [23:0] rsp_text_length;
   logic        rsp_last;
   logic        rsp_stall = 1'b0;

   config_text_tokenizer_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_item(req_item), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_kind(rsp_kind), .rsp_start_line(rsp_start_line),
      .rsp_start_column(rsp_start_column), .rsp_text_offset(rsp_text_offset),
      .rsp_text_length(rsp_text_length), .rsp_last(rsp_last), .rsp_stall(rsp_stall)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // scanner state mirrored by the predictor
   mode_type    scan_st = MODE_IDLE;
   logic [19:0] cur_line = 1;
   logic [15:0] cur_col = 1;
   logic [23:0] cur_off = 0;
   logic [19:0] tok_line = 1;
   logic [15:0] tok_col = 1;
   logic [23:0] tok_off = 0;
   logic [23:0] tok_len = 0;
   logic [3:0]  kw_prog = KW_NONE;
   bit          stream_done = 0;

   token_desc_type expected_tokens[$];
   token_desc_type step_tokens[$];
   int        mismatches = 0;
   int        bytes_sent = 0;
   bit        quiet = 0;
   bit        no_gaps = 0;
   int        hold_left = 0;
   int        seg_left = 0;
   bit        seg_stall = 0;

   function automatic bit c_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic bit c_letter(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic bit c_blank(input logic [7:0] c);
      return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
   endfunction

   function automatic bit c_word(input logic [7:0] c);
      return c_letter(c) || c_digit(c) || c == CH_UNDER || c == CH_HASH;
   endfunction

   // next letter needed to stay on a keyword
   function automatic logic [7:0] keyword_letter(input logic [3:0] p);
      case (p)
         4'd1:    return "r";
         4'd2:    return "u";
         4'd3:    return "e";
         4'd5:    return "a";
         4'd6:    return "l";
         4'd7:    return "s";
         4'd8:    return "e";
         default: return 8'd0;
      endcase
   endfunction

   function automatic logic [4:0] single_kind(input logic [7:0] c);
      case (c)
         "[":     return KIND_LBRACK;
         "]":     return KIND_RBRACK;
         "(":     return KIND_LPAREN;
         ")":     return KIND_RPAREN;
         "-":     return KIND_MINUS;
         "*":     return KIND_STAR;
         "%":     return KIND_PERCENT;
         "{":     return KIND_LBRACE;
         "}":     return KIND_RBRACE;
         ",":     return KIND_COMMA;
         ":":     return KIND_COLON;
         "@":     return KIND_AT;
         "$":     return KIND_DOLLAR;
         "!":     return KIND_BANG;
         "?":     return KIND_QUEST;
         default: return KIND_UNEXP;
      endcase
   endfunction

   function automatic logic [4:0] word_kind();
      return (kw_prog == KW_TRUE || kw_prog == KW_FALSE) ? KIND_BOOL : KIND_IDENT;
   endfunction

   task automatic push_token(input logic [4:0] k, input logic [19:0] ln,
                             input logic [15:0] cl, input logic [23:0] of,
                             input logic [23:0] ln2);
      token_desc_type t;
      t.kind = k; t.line = ln; t.col = cl; t.off = of; t.len = ln2; t.last = 0;
      if (step_tokens.size() < 2) step_tokens.insert(step_tokens.size(), t);
   endtask

   task automatic close_token(input logic [4:0] k);
      push_token(k, tok_line, tok_col, tok_off, tok_len);
   endtask

   // position advance with saturation
   task automatic move_on(input logic [7:0] c, input bit count_lines);
      if (~&cur_off) cur_off++;
      if (count_lines && c == CH_NL) begin
         if (~&cur_line) cur_line++;
         cur_col = 1;
      end else if (~&cur_col) begin
         cur_col++;
      end
   endtask

   task automatic lengthen();
      if (~&tok_len) tok_len++;
   endtask

   // byte scanned from the state between tokens
   task automatic scan_fresh(input logic [7:0] c);
      scan_st = MODE_IDLE;
      if (c_blank(c)) begin
         move_on(c, 1);
         return;
      end
      tok_line = cur_line; tok_col = cur_col; tok_off = cur_off; tok_len = 1;
      if (c == "/") scan_st = MODE_SLASH;
      else if (c == "+") scan_st = MODE_PLUS;
      else if (c_letter(c) || c == CH_UNDER || c == CH_HASH) begin
         scan_st = MODE_IDENT;
         kw_prog = (c == "t") ? KW_T : (c == "f") ? KW_F : KW_NONE;
      end else if (c == "=") close_token(KIND_EQUALS);
      else if (c == CH_QUOTE) begin
         scan_st = MODE_STRING;
         tok_off = (&cur_off) ? cur_off : cur_off + 1;
         tok_len = 0;
      end else if (c_digit(c)) scan_st = MODE_NUMBER;
      else if (c == ".") scan_st = MODE_DOT;
      else close_token(single_kind(c));
      move_on(c, 1);
   endtask

   task automatic tokenize_step(input logic [7:0] c, input bit is_end);
      logic [7:0] want;
      step_tokens.delete();
      if (stream_done) return;
      if (is_end) begin
         case (scan_st)
            MODE_IDENT:              close_token(word_kind());
            MODE_NUMBER:             close_token(KIND_NUMBER);
            MODE_STRING:             close_token(KIND_OPENSTR);
            MODE_SLASH:              close_token(KIND_SLASH);
            MODE_PLUS:               close_token(KIND_PLUS);
            MODE_DOT:                close_token(KIND_DOT);
            MODE_BLOCK, MODE_BSTAR:  close_token(KIND_OPENCOM);
            default: ;
         endcase
         push_token(KIND_EOF, cur_line, cur_col, cur_off, '0);
         scan_st = MODE_IDLE;
         stream_done = 1;
      end else begin
         case (scan_st)
            MODE_IDENT:
               if (c_word(c)) begin
                  want = keyword_letter(kw_prog);
                  kw_prog = (want != 0 && c == want) ? kw_prog + 4'd1 : KW_NONE;
                  lengthen();
                  move_on(c, 1);
               end else begin
                  close_token(word_kind());
                  scan_fresh(c);
               end
            MODE_NUMBER:
               if (c_digit(c) || c == ".") begin
                  lengthen();
                  move_on(c, 1);
               end else begin
                  close_token(KIND_NUMBER);
                  scan_fresh(c);
               end
            MODE_STRING: begin
               if (c == CH_QUOTE) begin
                  close_token(KIND_STRING);
                  scan_st = MODE_IDLE;
               end else lengthen();
               move_on(c, 0);
            end
            MODE_SLASH:
               if (c == "/") begin
                  scan_st = MODE_LINECOM;
                  move_on(c, 1);
               end else if (c == "*") begin
                  scan_st = MODE_BLOCK;
                  lengthen();
                  move_on(c, 1);
               end else begin
                  close_token(KIND_SLASH);
                  scan_fresh(c);
               end
            MODE_PLUS:
               if (c == "=") begin
                  tok_len = 2;
                  close_token(KIND_PLUSEQ);
                  scan_st = MODE_IDLE;
                  move_on(c, 1);
               end else begin
                  close_token(KIND_PLUS);
                  scan_fresh(c);
               end
            MODE_DOT:
               if (c_digit(c)) begin
                  scan_st = MODE_NUMBER;
                  lengthen();
                  move_on(c, 1);
               end else begin
                  close_token(KIND_DOT);
                  scan_fresh(c);
               end
            MODE_LINECOM:
               if (c == CH_NL) scan_fresh(c);
               else move_on(c, 0);
            MODE_BLOCK, MODE_BSTAR: begin
               lengthen();
               if (scan_st == MODE_BSTAR && c == "/") scan_st = MODE_IDLE;
               else scan_st = (c == "*") ? MODE_BSTAR : MODE_BLOCK;
               move_on(c, 1);
            end
            default: scan_fresh(c);
         endcase
      end
      if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1;
      foreach (step_tokens[i]) expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
   endtask

   // offer one item, wait for it to be taken, then maybe idle for a burst
   task automatic feed_byte(input logic [7:0] c, input bit is_end);
      req_valid <= 1'b1;
      req_item.ch <= c;
      req_item.is_end <= is_end;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tokenize_step(c, is_end);
      bytes_sent++;
      if (!quiet && !no_gaps && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic feed_text(input string s);
      for (int i = 0; i < s.len(); i++) feed_byte(s[i], 0);
   endtask

   // receiver stall: long hold-off on request, none when quiet, else random bursts
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
         seg_left = 0;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         if (seg_left == 0) begin
            seg_stall = ($urandom_range(0, 3) == 0);
            seg_left = $urandom_range(1, 19);
         end
         seg_left--;
         rsp_stall <= seg_stall;
      end
   end

   // compare each taken result with the oldest expected token
   always @(posedge clock) begin
      token_desc_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tokens.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: kind %0d line %0d col %0d", rsp_kind,
                        rsp_start_line, rsp_start_column);
         end else begin
            e = expected_tokens.pop_front();
            if (rsp_kind !== e.kind || rsp_start_line !== e.line ||
                rsp_start_column !== e.col || rsp_text_offset !== e.off ||
                rsp_text_length !== e.len || rsp_last !== e.last) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch: exp k%0d l%0d c%0d o%0d n%0d last%0d, ",
                            "got k%0d l%0d c%0d o%0d n%0d last%0d"},
                           e.kind, e.line, e.col, e.off, e.len, e.last, rsp_kind,
                           rsp_start_line, rsp_start_column, rsp_text_offset,
                           rsp_text_length, rsp_last);
            end
         end
      end
   end

   // keywords, identifiers, numbers, strings, comments, unexpected bytes and all single-byte kinds
   task automatic test_directed();
      feed_text("true false truex fals #a_1=+=+[](){}-*%,:@$!?.5 .x 1.2.");
      feed_text("\"s\nq\"//c\n/*a**/\n");
      feed_byte(8'h80, 0);
      feed_byte(8'hFF, 0);
      feed_byte(8'h00, 0);
      feed_text("/x\t");
   endtask

   // receiver holds off while the sender keeps pushing results
   task automatic test_backpressure();
      no_gaps = 1;
      hold_left = 120;
      for (int i = 0; i < 40; i++) feed_byte("[", 0);
      no_gaps = 0;
   endtask

   task automatic random_word();
      string pool;
      int    n;
      pool = "abcdefghijklmnopqrstuvwxyzXYZ0123456789_#";
      case ($urandom_range(0, 5))
         0: feed_text("true");
         1: feed_text("false");
         2: feed_text("tru");
         3: feed_text("falsey");
         default: begin
            n = $urandom_range(1, 6);
            feed_byte(pool[$urandom_range(0, 25)], 0);
            for (int i = 1; i < n; i++) feed_byte(pool[$urandom_range(0, pool.len()-1)], 0);
         end
      endcase
   endtask

   task automatic random_token();
      string marks;
      logic [7:0] c;
      marks = "[](){}-*%,:@$!?=";
      case ($urandom_range(0, 13))
         0, 1: random_word();
         2: begin
            if ($urandom_range(0, 1)) feed_byte(".", 0);
            repeat ($urandom_range(1, 4))
               feed_byte($urandom_range(0, 4) == 0 ? "." : 8'($urandom_range(48, 57)), 0);
         end
         3: begin
            feed_byte(CH_QUOTE, 0);
            repeat ($urandom_range(0, 6)) begin
               c = 8'($urandom_range(0, 255));
               if (c == CH_QUOTE) c = CH_NL;
               feed_byte(c, 0);
            end
            feed_byte(CH_QUOTE, 0);
         end
         4: begin
            feed_text("//");
            repeat ($urandom_range(0, 5)) feed_byte(8'($urandom_range(32, 126)), 0);
            feed_byte(CH_NL, 0);
         end
         5: begin
            feed_text("/*");
            repeat ($urandom_range(0, 5)) begin
               c = 8'($urandom_range(0, 255));
               if (c == "/") c = "*";
               feed_byte(c, 0);
            end
            feed_text("*/");
         end
         6, 7: feed_byte(marks[$urandom_range(0, marks.len()-1)], 0);
         8: feed_text($urandom_range(0, 1) ? "+=" : "+");
         9: feed_text($urandom_range(0, 1) ? "/" : ".");
         10: feed_byte(8'($urandom_range(8, 13)), 0);
         11: feed_byte(8'($urandom_range(0, 255)), 0);
         default: feed_byte(" ", 0);
      endcase
      if ($urandom_range(0, 2) == 0) feed_byte($urandom_range(0, 3) == 0 ? CH_NL : " ", 0);
   endtask

   task automatic test_random(input int count);
      int goal;
      goal = bytes_sent + count;
      while (bytes_sent < goal) random_token();
   endtask

   // end marker from a randomly chosen pending state, then bytes and a second end marker that must be ignored
   task automatic test_end_marker();
      case ($urandom_range(0, 6))
         0: feed_text("abc");
         1: feed_text("\"open");
         2: feed_text("/* open");
         3: feed_text("+");
         4: feed_text(".");
         5: feed_text("/");
         default: feed_text(" ");
      endcase
      feed_byte(8'h00, 1);
      feed_byte("a", 0);
      feed_byte(8'hFF, 1);
      feed_byte("[", 0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random(1700);
      quiet = 1;
      test_random(300);
      test_end_marker();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && expected_tokens.size() == 0)
         $display("config_text_tokenizer_top test passed");
      else
         $display("config_text_tokenizer_top test failed");
      $finish;
   end

   // watchdog
   initial begin
      #20ms;
      $display("config_text_tokenizer_top test failed");
      $finish;
   end

endmodule
